>>> rtl/mhcc_pkg.sv
// Shared types and constants for the magic hash collision check core.
// No dependencies; imported by the input channel interface and the core.
`default_nettype none

package mhcc_pkg;

	localparam int KEY_W       = 64;
	localparam int VALUE_W     = 64;
	localparam int SHIFT_W     = 6;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 64;
	localparam int EPOCH_BITS  = 8;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] CFG_MULTIPLIER = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHIFT      = 1'd1;

	localparam logic [KEY_W-1:0]   MULT_RESET  = '0;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd52;

	// tag zero marks a cleared entry, live trials use tags 1..max
	localparam logic [EPOCH_BITS-1:0] EPOCH_CLEAR = '0;
	localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
	localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

	typedef struct packed {
		logic [EPOCH_BITS-1:0] tag;
		logic [VALUE_W-1:0]    value;
	} entry_t;

endpackage

`default_nettype wire

>>> rtl/mhcc_if.sv
// Valid/ready channel interfaces for the magic hash collision check core.
// Depends on mhcc_pkg for field widths.
`default_nettype none

interface mhcc_in_if import mhcc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KEY_W-1:0]   occupancy_key;
	logic [VALUE_W-1:0] attack_value;
	logic               last_item;

	modport source (output valid, output occupancy_key, output attack_value,
		output last_item, input ready);
	modport sink (input valid, input occupancy_key, input attack_value,
		input last_item, output ready);
endinterface

interface mhcc_out_if ();
	logic valid;
	logic ready;
	logic collision_free;

	modport source (output valid, output collision_free, input ready);
	modport sink (input valid, input collision_free, output ready);
endinterface

`default_nettype wire

>>> rtl/magic_hash_collision_check_core.sv
// Magic hash collision check core: hashes items into a tagged table memory.
// Depends on mhcc_pkg and the channel interfaces in mhcc_if.sv.
// An item is accepted in the idle state, then passes through states for three
// 32x32 partial products of key times multiplier, for adding them, for the
// synchronous table read and for check and write back, and only then can the
// next item be taken. Only one item is in flight, so table accesses never
// overlap. A result item appears for each item marked last; the core stalls
// in write-back only if that item is marked last and a previous result is
// still waiting. Table entries carry an 8-bit trial tag instead of being
// cleared after each trial; after reset, and after every 255th trial, a
// clearing pass writes all 2^TABLE_BITS entries, taking no item meanwhile.
`default_nettype none

module magic_hash_collision_check_core import mhcc_pkg::*; #(
	parameter int TABLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	mhcc_in_if.sink                item_in,
	mhcc_out_if.source             result_out
);

	localparam int DEPTH = 1 << TABLE_BITS;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_READ,
		ST_CHECK
	} state_t;

	state_t                  state_q;
	logic [TABLE_BITS-1:0]   clr_addr_q;
	logic [EPOCH_BITS-1:0]   epoch_q;
	logic                    fail_q;
	logic                    out_valid_q;
	logic                    collision_free_q;

	logic [KEY_W-1:0]        multiplier_q;
	logic [SHIFT_W-1:0]      shift_q;

	logic [KEY_W-1:0]        key_q;
	logic [VALUE_W-1:0]      val_q;
	logic                    last_q;
	logic [63:0]             pp_ll_q;
	logic [31:0]             pp_lh_q;
	logic [31:0]             pp_hl_q;
	logic [KEY_W-1:0]        product_q;

	logic [63:0]             mul_ll;
	logic [31:0]             mul_lh;
	logic [31:0]             mul_hl;
	logic [TABLE_BITS-1:0]   slot_c;
	logic [VALUE_W-1:0]      stored_c;
	logic                    collide_c;
	logic                    proceed_c;

	entry_t                  mem [DEPTH];
	entry_t                  rdata_q;
	logic                    mem_we;
	logic [TABLE_BITS-1:0]   mem_waddr;
	entry_t                  mem_wdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multiplier_q <= MULT_RESET;
			shift_q      <= SHIFT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_MULTIPLIER: multiplier_q <= cfg_data;
				CFG_SHIFT:      shift_q      <= cfg_data[SHIFT_W-1:0];
			endcase
		end
	end

	// low 64 bits of key * multiplier from three 32x32 partial products;
	// the cross terms only matter in their low 32 bits
	assign mul_ll = key_q[31:0] * multiplier_q[31:0];
	assign mul_lh = key_q[31:0] * multiplier_q[63:32];
	assign mul_hl = key_q[63:32] * multiplier_q[31:0];

	// index wraps to the table size when the shift leaves more bits
	assign slot_c    = TABLE_BITS'(product_q >> shift_q);
	assign stored_c  = (rdata_q.tag == epoch_q) ? rdata_q.value : '0;
	assign collide_c = (stored_c != '0) && (stored_c != val_q);
	assign proceed_c = !last_q || !out_valid_q || result_out.ready;

	assign item_in.ready           = (state_q == ST_IDLE);
	assign result_out.valid        = out_valid_q;
	assign result_out.collision_free = collision_free_q;

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			key_q  <= item_in.occupancy_key;
			val_q  <= item_in.attack_value;
			last_q <= item_in.last_item;
		end
		pp_ll_q   <= mul_ll;
		pp_lh_q   <= mul_lh;
		pp_hl_q   <= mul_hl;
		product_q <= pp_ll_q + {pp_lh_q + pp_hl_q, 32'd0};
	end

	// table memory: one write port, one registered read port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_c;
		mem_wdata = '{tag: epoch_q, value: val_q};
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '{tag: EPOCH_CLEAR, value: '0};
		end else if (state_q == ST_CHECK && proceed_c && !collide_c) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[slot_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_CLEAR;
			clr_addr_q       <= '0;
			epoch_q          <= EPOCH_FIRST;
			fail_q           <= 1'b0;
			out_valid_q      <= 1'b0;
			collision_free_q <= 1'b0;
		end else begin
			if (out_valid_q && result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_in.valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_READ;
				ST_READ: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (proceed_c) begin
						if (last_q) begin
							out_valid_q      <= 1'b1;
							collision_free_q <= !(fail_q || collide_c);
							fail_q           <= 1'b0;
							if (epoch_q == EPOCH_LAST) begin
								epoch_q <= EPOCH_FIRST;
								state_q <= ST_CLEAR;
							end else begin
								epoch_q <= epoch_q + 1'b1;
								state_q <= ST_IDLE;
							end
						end else begin
							if (collide_c) begin
								fail_q <= 1'b1;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// a cleared tag must never match the live trial
	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != EPOCH_CLEAR)
		else $error("trial tag reached the cleared value");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_out.valid) |-> $past(state_q == ST_CHECK && last_q))
		else $error("result item without a last item");

	a_fail_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && proceed_c && last_q) |=> !fail_q)
		else $error("fail flag survived the end of a trial");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_CHECK))
		else $error("table write outside clear or write-back");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && !proceed_c) |=>
			(state_q == ST_CHECK && $stable(rdata_q)))
		else $error("write-back stall lost its read data");

endmodule

`default_nettype wire
